FILE: rtl/core/sme_pkg.sv
`default_nettype none
package sme_pkg;

    localparam int CMD_W    = 5;
    localparam int WORD_W   = 64;
    localparam int CODE_AW  = 16;
    localparam int STATUS_W = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [CODE_AW-1:0]  t_code_addr;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [CMD_W-1:0]    t_opcode;

    localparam t_opcode OP_PUSH  = 5'd0;
    localparam t_opcode OP_OUT   = 5'd1;
    localparam t_opcode OP_HLT   = 5'd2;
    localparam t_opcode OP_ADD   = 5'd3;
    localparam t_opcode OP_SUB   = 5'd4;
    localparam t_opcode OP_MUL   = 5'd5;
    localparam t_opcode OP_DIV   = 5'd6;
    localparam t_opcode OP_SQRT  = 5'd7;
    localparam t_opcode OP_PUSHR = 5'd8;
    localparam t_opcode OP_POPR  = 5'd9;
    localparam t_opcode OP_JMP   = 5'd10;
    localparam t_opcode OP_JB    = 5'd11;
    localparam t_opcode OP_JBE   = 5'd12;
    localparam t_opcode OP_JA    = 5'd13;
    localparam t_opcode OP_JAE   = 5'd14;
    localparam t_opcode OP_JE    = 5'd15;
    localparam t_opcode OP_JNE   = 5'd16;
    localparam t_opcode OP_CALL  = 5'd17;
    localparam t_opcode OP_RET   = 5'd18;
    localparam t_opcode OP_PUSHM = 5'd19;
    localparam t_opcode OP_POPM  = 5'd20;
    localparam t_opcode OP_PUSHV = 5'd21;
    localparam t_opcode OP_POPV  = 5'd22;
    localparam t_opcode OP_DRW   = 5'd23;
    localparam t_opcode OP_PAUSE = 5'd24;

    localparam t_status ST_RUN     = 4'd0;
    localparam t_status ST_HALT    = 4'd1;
    localparam t_status ST_END     = 4'd2;
    localparam t_status ST_DIVZ    = 4'd3;
    localparam t_status ST_SQRTNEG = 4'd4;
    localparam t_status ST_BADREG  = 4'd5;
    localparam t_status ST_RAM     = 4'd6;
    localparam t_status ST_VRAM    = 4'd7;
    localparam t_status ST_UNDER   = 4'd8;
    localparam t_status ST_OVER    = 4'd9;
    localparam t_status ST_RETF    = 4'd10;
    localparam t_status ST_BADOP   = 4'd11;

    localparam logic [APB_AW-1:0] REG_PROGRAM_LENGTH = 3'd0;

    typedef logic [1:0] t_arith_op;
    localparam t_arith_op AR_MUL  = 2'd0;
    localparam t_arith_op AR_DIV  = 2'd1;
    localparam t_arith_op AR_SQRT = 2'd2;

    typedef struct packed {
        logic accept;
        logic rd_second;
        logic commit;
        logic arith_start;
        logic clr_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic needs_arith;
        logic arith_done;
        logic clr_done;
        logic out_busy;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: rtl/core/sme_cmd_if.sv
`default_nettype none
interface sme_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [sme_pkg::CMD_W-1:0]   command;
    logic signed [sme_pkg::WORD_W-1:0] operand;

    modport source (output valid, output command, output operand, input ready);
    modport sink   (input valid, input command, input operand, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sme_res_if.sv
`default_nettype none
interface sme_res_if;
    logic                           valid;
    logic                           ready;
    logic [sme_pkg::CODE_AW-1:0]    next_address;
    logic                           print_valid;
    logic signed [sme_pkg::WORD_W-1:0] print_value;
    logic                           draw_request;
    logic                           pause_request;
    logic [sme_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output next_address, output print_valid,
                    output print_value, output draw_request, output pause_request,
                    output status, input ready);
    modport sink   (input valid, input next_address, input print_valid,
                    input print_value, input draw_request, input pause_request,
                    input status, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sme_arith.sv
`default_nettype none
module sme_arith (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire sme_pkg::t_arith_op   i_op,
    input  wire sme_pkg::t_word       i_a,
    input  wire sme_pkg::t_word       i_b,
    output logic                      o_done,
    output sme_pkg::t_word            o_result
);
    import sme_pkg::*;

    localparam int CNT_W = 7;

    logic             r_busy;
    logic             r_done;
    t_arith_op        r_op;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_x;
    t_word            r_y;
    t_word            r_acc;
    t_word            r_prod;
    t_word            r_res;
    logic             r_neg;

    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [64:0] w_div_t;
    logic [64:0] w_div_diff;
    t_word       w_sq_sum;
    logic        w_sq_ge;
    t_word       w_sq_y;

    // One 32x32 multiplier shared by the three partial products.
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    begin w_ma = r_x[31:0];  w_mb = r_y[31:0];  end
            2'd1:    begin w_ma = r_x[31:0];  w_mb = r_y[63:32]; end
            default: begin w_ma = r_x[63:32]; w_mb = r_y[31:0];  end
        endcase
    end

    assign w_div_t    = {r_acc, r_x[63]};
    assign w_div_diff = w_div_t - {1'b0, r_y};
    assign w_sq_sum   = r_y + r_acc;
    assign w_sq_ge    = (r_x >= w_sq_sum);
    assign w_sq_y     = w_sq_ge ? ((r_y >> 1) + r_acc) : (r_y >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            unique case (r_op)
                AR_MUL: begin
                    if (r_cnt == CNT_W'(3)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
                AR_DIV: begin
                    if (r_cnt == CNT_W'(64)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
                default: begin
                    if (r_cnt == CNT_W'(31)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_cnt <= '0;
            unique case (i_op)
                AR_MUL: begin
                    r_x   <= i_a;
                    r_y   <= i_b;
                    r_acc <= '0;
                end
                AR_DIV: begin
                    r_x   <= i_a[63] ? (WORD_W'(0) - i_a) : i_a;
                    r_y   <= i_b[63] ? (WORD_W'(0) - i_b) : i_b;
                    r_acc <= '0;
                    r_neg <= i_a[63] ^ i_b[63];
                end
                default: begin
                    r_x   <= i_b;
                    r_y   <= '0;
                    r_acc <= t_word'(64'h4000_0000_0000_0000);
                end
            endcase
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            unique case (r_op)
                AR_MUL: begin
                    r_prod <= {32'b0, w_ma} * {32'b0, w_mb};
                    if (r_cnt == CNT_W'(1)) begin
                        r_acc <= r_prod;
                    end else if (r_cnt == CNT_W'(2)) begin
                        r_acc <= r_acc + {r_prod[31:0], 32'b0};
                    end else if (r_cnt == CNT_W'(3)) begin
                        r_res <= r_acc + {r_prod[31:0], 32'b0};
                    end
                end
                AR_DIV: begin
                    if (r_cnt == CNT_W'(64)) begin
                        r_res <= r_neg ? (WORD_W'(0) - r_x) : r_x;
                    end else begin
                        r_acc <= w_div_diff[64] ? w_div_t[63:0] : w_div_diff[63:0];
                        r_x   <= {r_x[62:0], ~w_div_diff[64]};
                    end
                end
                default: begin
                    if (w_sq_ge) begin
                        r_x <= r_x - w_sq_sum;
                    end
                    r_y   <= w_sq_y;
                    r_acc <= r_acc >> 2;
                    if (r_cnt == CNT_W'(31)) begin
                        r_res <= w_sq_y;
                    end
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

FILE: rtl/core/sme_ctrl.sv
`default_nettype none
module sme_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire sme_pkg::t_dp_stat  i_stat,
    output sme_pkg::t_ctrl_cmd      o_cmd
);
    import sme_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD2   = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_ARITH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RD2;
                end
            end
            S_RD2: begin
                o_cmd.rd_second = 1'b1;
                n_state         = S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.needs_arith) begin
                    o_cmd.arith_start = 1'b1;
                    n_state           = S_ARITH;
                end else if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ARITH: begin
                if (i_stat.arith_done && !i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sme_datapath.sv
`default_nettype none
module sme_datapath #(
    parameter int REGISTER_COUNT = 4,
    parameter int RAM_WORDS      = 1024,
    parameter int VRAM_WORDS     = 1024,
    parameter int STACK_DEPTH    = 64,
    parameter int RETURN_DEPTH   = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sme_pkg::t_ctrl_cmd    i_cmd,
    output sme_pkg::t_dp_stat          o_stat,
    input  wire sme_pkg::t_opcode      i_command,
    input  wire sme_pkg::t_word        i_operand,
    input  wire sme_pkg::t_code_addr   i_program_length,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output sme_pkg::t_code_addr        o_next_address,
    output logic                       o_print_valid,
    output sme_pkg::t_word             o_print_value,
    output logic                       o_draw_request,
    output logic                       o_pause_request,
    output sme_pkg::t_status           o_status
);
    import sme_pkg::*;

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W   = $clog2(STACK_DEPTH);
    localparam int RL_W   = $clog2(RETURN_DEPTH + 1);
    localparam int RA_W   = $clog2(RETURN_DEPTH);
    localparam int RIDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int RAM_AW = $clog2(RAM_WORDS);
    localparam int VRM_AW = $clog2(VRAM_WORDS);
    localparam int MAXW   = (RAM_WORDS > VRAM_WORDS) ? RAM_WORDS : VRAM_WORDS;
    localparam int CLR_W  = $clog2(MAXW);

    // Architectural state.
    t_opcode          r_cmd;
    t_word            r_opd;
    t_code_addr       r_ip;
    t_status          r_run;
    logic [LVL_W-1:0] r_level;
    logic [RL_W-1:0]  r_rlevel;
    t_word            r_regs [REGISTER_COUNT];
    t_word            r_stack [STACK_DEPTH];
    t_code_addr       r_rstack [RETURN_DEPTH];
    t_word            r_ram [RAM_WORDS];
    t_word            r_vram [VRAM_WORDS];
    t_word            r_sdata;
    t_word            r_b;
    t_code_addr       r_ret_q;
    t_word            r_ram_q;
    t_word            r_vram_q;
    logic [CLR_W-1:0] r_clr_cnt;

    logic             r_out_valid;
    t_code_addr       r_out_addr;
    logic             r_out_pvalid;
    t_word            r_out_pvalue;
    logic             r_out_drw;
    logic             r_out_pause;
    t_status          r_out_status;

    // Arithmetic unit.
    t_arith_op w_ar_op;
    logic      w_ar_done;
    t_word     w_ar_res;

    // Accept-time lookups.
    logic  w_acc_reg_ok;
    t_word w_acc_regval;

    // Evaluation.
    t_word            w_a;
    t_word            w_b;
    logic             w_run_ok;
    logic             w_end_start;
    t_code_addr       w_step1;
    t_code_addr       w_step2;
    t_code_addr       w_target;
    logic             w_full;
    logic             w_ge1;
    logic             w_ge2;
    logic             w_ret_full;
    logic             w_ret_empty;
    logic             w_reg_ok;
    t_word            w_regval;
    logic             w_ram_ok;
    logic             w_vram_ok;
    logic             w_take;
    t_word            w_alu;
    logic [LVL_W-1:0] w_lvl_m1;
    logic [LVL_W-1:0] w_lvl_m2;
    logic [RL_W-1:0]  w_rl_m1;

    t_status          w_st;
    t_code_addr       w_nxt;
    t_status          w_st_f;
    t_code_addr       w_nxt_f;
    logic             w_s_we;
    logic [SA_W-1:0]  w_s_wa;
    t_word            w_s_wd;
    logic [LVL_W-1:0] w_lvl_n;
    logic [RL_W-1:0]  w_rl_n;
    logic             w_ret_we;
    logic             w_reg_we;
    logic             w_ram_we;
    logic             w_vram_we;
    logic             w_pvalid;
    logic             w_drw;
    logic             w_pause;
    logic             w_arith;
    logic             w_commit_run;

    logic             w_ram_clr;
    logic             w_vram_clr;

    assign w_acc_reg_ok = (i_operand < 64'(REGISTER_COUNT));
    assign w_acc_regval = w_acc_reg_ok ? r_regs[i_operand[RIDX_W-1:0]] : '0;

    assign w_a         = r_sdata;
    assign w_b         = r_b;
    assign w_end_start = (r_run == ST_RUN) && (r_ip >= i_program_length);
    assign w_run_ok    = (r_run == ST_RUN) && (r_ip < i_program_length);
    assign w_step1     = r_ip + CODE_AW'(1);
    assign w_step2     = r_ip + CODE_AW'(2);
    assign w_target    = r_opd[CODE_AW-1:0];
    assign w_full      = (r_level == LVL_W'(STACK_DEPTH));
    assign w_ge1       = (r_level != '0);
    assign w_ge2       = (r_level >= LVL_W'(2));
    assign w_ret_full  = (r_rlevel == RL_W'(RETURN_DEPTH));
    assign w_ret_empty = (r_rlevel == '0);
    assign w_reg_ok    = (r_opd < 64'(REGISTER_COUNT));
    assign w_regval    = w_reg_ok ? r_regs[r_opd[RIDX_W-1:0]] : '0;
    assign w_ram_ok    = (w_regval < 64'(RAM_WORDS));
    assign w_vram_ok   = (w_regval < 64'(VRAM_WORDS));
    assign w_lvl_m1    = r_level - LVL_W'(1);
    assign w_lvl_m2    = r_level - LVL_W'(2);
    assign w_rl_m1     = r_rlevel - RL_W'(1);
    assign w_alu       = (r_cmd == OP_SUB) ? (w_a - w_b) : (w_a + w_b);

    // Compares treat both stack words as signed; a is below the top word b.
    always_comb begin
        unique case (r_cmd)
            OP_JB:   w_take = ($signed(w_a) <  $signed(w_b));
            OP_JBE:  w_take = ($signed(w_a) <= $signed(w_b));
            OP_JA:   w_take = ($signed(w_a) >  $signed(w_b));
            OP_JAE:  w_take = ($signed(w_a) >= $signed(w_b));
            OP_JE:   w_take = (w_a == w_b);
            OP_JNE:  w_take = (w_a != w_b);
            default: w_take = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_cmd)
            OP_MUL:  w_ar_op = AR_MUL;
            OP_DIV:  w_ar_op = AR_DIV;
            default: w_ar_op = AR_SQRT;
        endcase
    end

    always_comb begin
        w_st      = ST_RUN;
        w_nxt     = r_ip;
        w_s_we    = 1'b0;
        w_s_wa    = r_level[SA_W-1:0];
        w_s_wd    = r_opd;
        w_lvl_n   = r_level;
        w_rl_n    = r_rlevel;
        w_ret_we  = 1'b0;
        w_reg_we  = 1'b0;
        w_ram_we  = 1'b0;
        w_vram_we = 1'b0;
        w_pvalid  = 1'b0;
        w_drw     = 1'b0;
        w_pause   = 1'b0;
        w_arith   = 1'b0;
        unique case (r_cmd)
            OP_PUSH: begin
                if (w_full) begin
                    w_st = ST_OVER;
                end else begin
                    w_s_we  = 1'b1;
                    w_lvl_n = r_level + LVL_W'(1);
                    w_nxt   = w_step2;
                end
            end
            OP_OUT: begin
                if (!w_ge1) begin
                    w_st = ST_UNDER;
                end else begin
                    w_pvalid = 1'b1;
                    w_lvl_n  = w_lvl_m1;
                    w_nxt    = w_step1;
                end
            end
            OP_HLT: begin
                w_st = ST_HALT;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (!w_ge2) begin
                    w_st = ST_UNDER;
                end else if ((r_cmd == OP_DIV) && (w_b == '0)) begin
                    w_st = ST_DIVZ;
                end else begin
                    w_arith = (r_cmd == OP_MUL) || (r_cmd == OP_DIV);
                    w_s_we  = 1'b1;
                    w_s_wa  = w_lvl_m2[SA_W-1:0];
                    w_s_wd  = w_arith ? w_ar_res : w_alu;
                    w_lvl_n = w_lvl_m1;
                    w_nxt   = w_step1;
                end
            end
            OP_SQRT: begin
                if (!w_ge1) begin
                    w_st = ST_UNDER;
                end else if (w_b[WORD_W-1]) begin
                    w_st = ST_SQRTNEG;
                end else begin
                    w_arith = 1'b1;
                    w_s_we  = 1'b1;
                    w_s_wa  = w_lvl_m1[SA_W-1:0];
                    w_s_wd  = w_ar_res;
                    w_nxt   = w_step1;
                end
            end
            OP_PUSHR, OP_PUSHM, OP_PUSHV, OP_POPR, OP_POPM, OP_POPV: begin
                if (!w_reg_ok) begin
                    w_st = ST_BADREG;
                end else if (((r_cmd == OP_PUSHM) || (r_cmd == OP_POPM)) && !w_ram_ok) begin
                    w_st = ST_RAM;
                end else if (((r_cmd == OP_PUSHV) || (r_cmd == OP_POPV)) && !w_vram_ok) begin
                    w_st = ST_VRAM;
                end else if ((r_cmd == OP_PUSHR) || (r_cmd == OP_PUSHM)
                             || (r_cmd == OP_PUSHV)) begin
                    if (w_full) begin
                        w_st = ST_OVER;
                    end else begin
                        w_s_we  = 1'b1;
                        w_s_wd  = (r_cmd == OP_PUSHR) ? w_regval :
                                  (r_cmd == OP_PUSHM) ? r_ram_q : r_vram_q;
                        w_lvl_n = r_level + LVL_W'(1);
                        w_nxt   = w_step2;
                    end
                end else begin
                    if (!w_ge1) begin
                        w_st = ST_UNDER;
                    end else begin
                        w_lvl_n   = w_lvl_m1;
                        w_reg_we  = (r_cmd == OP_POPR);
                        w_ram_we  = (r_cmd == OP_POPM);
                        w_vram_we = (r_cmd == OP_POPV);
                        w_nxt     = w_step2;
                    end
                end
            end
            OP_JMP: begin
                w_nxt = w_target;
            end
            OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
                if (!w_ge2) begin
                    w_st = ST_UNDER;
                end else begin
                    w_lvl_n = w_lvl_m2;
                    w_nxt   = w_take ? w_target : w_step2;
                end
            end
            OP_CALL: begin
                if (w_ret_full) begin
                    w_st = ST_RETF;
                end else begin
                    w_ret_we = 1'b1;
                    w_rl_n   = r_rlevel + RL_W'(1);
                    w_nxt    = w_target;
                end
            end
            OP_RET: begin
                if (w_ret_empty) begin
                    w_st = ST_RETF;
                end else begin
                    w_rl_n = w_rl_m1;
                    w_nxt  = r_ret_q;
                end
            end
            OP_DRW: begin
                w_drw = 1'b1;
                w_nxt = w_step1;
            end
            OP_PAUSE: begin
                w_pause = 1'b1;
                w_nxt   = w_step1;
            end
            default: begin
                w_st = ST_BADOP;
            end
        endcase
    end

    // A fault or halt leaves the pointer on the instruction; a pointer that lands
    // past the program ends the run.
    always_comb begin
        w_st_f  = w_st;
        w_nxt_f = w_nxt;
        if (w_st != ST_RUN) begin
            w_nxt_f = r_ip;
        end else if (w_nxt >= i_program_length) begin
            w_st_f = ST_END;
        end
    end

    assign w_commit_run = i_cmd.commit && w_run_ok;

    sme_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.arith_start),
        .i_op     (w_ar_op),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_done   (w_ar_done),
        .o_result (w_ar_res)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip      <= '0;
            r_run     <= ST_RUN;
            r_level   <= '0;
            r_rlevel  <= '0;
            r_clr_cnt <= '0;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
            if (w_commit_run) begin
                r_ip     <= w_nxt_f;
                r_run    <= w_st_f;
                r_level  <= w_lvl_n;
                r_rlevel <= w_rl_n;
                if (w_reg_we) begin
                    r_regs[r_opd[RIDX_W-1:0]] <= w_b;
                end
            end else if (i_cmd.commit && w_end_start) begin
                r_run <= ST_END;
            end
        end
    end

    // Latched instruction and the top stack word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_command;
            r_opd <= i_operand;
        end
        if (i_cmd.rd_second) begin
            r_b <= r_sdata;
        end
    end

    // Data stack: the top word is read at accept, the one below it in the cycle after.
    always_ff @(posedge i_clk) begin
        if (w_commit_run && w_s_we) begin
            r_stack[w_s_wa] <= w_s_wd;
        end
        if (i_cmd.accept) begin
            r_sdata <= r_stack[w_lvl_m1[SA_W-1:0]];
        end else if (i_cmd.rd_second) begin
            r_sdata <= r_stack[w_lvl_m2[SA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit_run && w_ret_we) begin
            r_rstack[r_rlevel[RA_W-1:0]] <= w_step2;
        end
        if (i_cmd.accept) begin
            r_ret_q <= r_rstack[w_rl_m1[RA_W-1:0]];
        end
    end

    assign w_ram_clr  = i_cmd.clr_step && ({1'b0, r_clr_cnt} < (CLR_W + 1)'(RAM_WORDS));
    assign w_vram_clr = i_cmd.clr_step && ({1'b0, r_clr_cnt} < (CLR_W + 1)'(VRAM_WORDS));

    always_ff @(posedge i_clk) begin
        if (w_ram_clr) begin
            r_ram[r_clr_cnt[RAM_AW-1:0]] <= '0;
        end else if (w_commit_run && w_ram_we) begin
            r_ram[w_regval[RAM_AW-1:0]] <= w_b;
        end
        if (i_cmd.accept) begin
            r_ram_q <= r_ram[w_acc_regval[RAM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vram_clr) begin
            r_vram[r_clr_cnt[VRM_AW-1:0]] <= '0;
        end else if (w_commit_run && w_vram_we) begin
            r_vram[w_regval[VRM_AW-1:0]] <= w_b;
        end
        if (i_cmd.accept) begin
            r_vram_q <= r_vram[w_acc_regval[VRM_AW-1:0]];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_addr   <= w_run_ok ? w_nxt_f : r_ip;
            r_out_status <= w_run_ok ? w_st_f : (w_end_start ? ST_END : r_run);
            r_out_pvalid <= w_run_ok && w_pvalid;
            r_out_pvalue <= (w_run_ok && w_pvalid) ? w_b : '0;
            r_out_drw    <= w_run_ok && w_drw;
            r_out_pause  <= w_run_ok && w_pause;
        end
    end

    assign o_stat.needs_arith = w_run_ok && w_arith;
    assign o_stat.arith_done  = w_ar_done;
    assign o_stat.clr_done    = i_cmd.clr_step && (r_clr_cnt == CLR_W'(MAXW - 1));
    assign o_stat.out_busy    = r_out_valid && !i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_next_address  = r_out_addr;
    assign o_print_valid   = r_out_pvalid;
    assign o_print_value   = r_out_pvalue;
    assign o_draw_request  = r_out_drw;
    assign o_pause_request = r_out_pause;
    assign o_status        = r_out_status;

endmodule
`default_nettype wire

FILE: rtl/core/stack_machine_executor.sv
// Stack machine executor: runs one fetched instruction per input word.
// The command channel (i_cmd) carries an opcode and the code word after it;
// a word is taken when valid and ready are both high. The result channel
// (o_res) returns one word per instruction: the next code address, print
// data, draw and pause requests and the sticky run status.
// program_length is written over the APB port at byte address 0; the user
// must do so only while the block is idle, which the block does not enforce.
// pready is always high. An instruction is taken with a read of the stack top,
// then the word below it is read, then it is evaluated and committed, and only
// then is the next word taken; mul, sqrt and div first wait on the arithmetic
// unit: the shared 32x32 multiplier for mul, a bit-serial unit for sqrt and div.
// After reset the RAM and video RAM are cleared one word per cycle, with the
// clear counter running over max(RAM_WORDS, VRAM_WORDS) words (1024 by
// default); no command is taken during that pass. The result word sits in an
// output register; while the receiver stalls, the next command is still taken
// and worked on, and it commits once the register is free.
`default_nettype none
module stack_machine_executor #(
    parameter int REGISTER_COUNT = 4,
    parameter int RAM_WORDS      = 1024,
    parameter int VRAM_WORDS     = 1024,
    parameter int STACK_DEPTH    = 64,
    parameter int RETURN_DEPTH   = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    sme_cmd_if.sink                           i_cmd,
    sme_res_if.source                         o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sme_pkg::APB_AW-1:0]   paddr,
    input  wire logic [sme_pkg::APB_DW-1:0]   pwdata,
    output logic [sme_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import sme_pkg::*;

    t_code_addr r_prog_len;
    t_ctrl_cmd  w_cmd;
    t_dp_stat   w_stat;
    logic       w_reg_sel;

    // Only the word index matters for decode; byte lanes are ignored.
    assign w_reg_sel = ({paddr[APB_AW-1:2], 2'b00} == REG_PROGRAM_LENGTH);
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? {{(APB_DW - CODE_AW){1'b0}}, r_prog_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= '0;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_prog_len <= pwdata[CODE_AW-1:0];
        end
    end

    sme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sme_datapath #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .RAM_WORDS      (RAM_WORDS),
        .VRAM_WORDS     (VRAM_WORDS),
        .STACK_DEPTH    (STACK_DEPTH),
        .RETURN_DEPTH   (RETURN_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_command        (i_cmd.command),
        .i_operand        (i_cmd.operand),
        .i_program_length (r_prog_len),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_next_address   (o_res.next_address),
        .o_print_valid    (o_res.print_valid),
        .o_print_value    (o_res.print_value),
        .o_draw_request   (o_res.draw_request),
        .o_pause_request  (o_res.pause_request),
        .o_status         (o_res.status)
    );

`ifndef ASSERT_OFF
    // One instruction at a time: a taken word closes the command channel.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command taken while an instruction is in flight");

    // No command is taken during the memory clearing pass.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_step |-> !i_cmd.ready)
        else $error("command channel open during memory clear");

    // A result is only committed into a free output register.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !w_stat.out_busy)
        else $error("result committed over a stalled result word");
`endif

endmodule
`default_nettype wire

FILE: test/tb_stack_machine_executor.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_stack_machine_executor;
    import sme_pkg::*;

    // Sizes of the block as instantiated (defaults of the RTL).
    localparam int REG_N      = 4;
    localparam int MEM_WORDS  = 1024;
    localparam int DSTK_DEPTH = 64;
    localparam int RSTK_DEPTH = 32;
    // Generated code stays below this address so that ordinary programs never
    // run into program_length, which is always at least 1000 until the end.
    localparam int SAFE_TOP   = 900;
    localparam int WATCHDOG   = 8000;

    typedef struct packed {
        t_opcode cmd;
        t_word   opd;
    } t_instr;

    typedef struct packed {
        t_code_addr addr;
        logic       pvalid;
        t_word      pvalue;
        logic       drw;
        logic       pause;
        t_status    st;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    sme_cmd_if cmd_bus ();
    sme_res_if res_bus ();

    stack_machine_executor uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Two copies of the machine state. Copy 0 follows the program as it is
    // generated so that the generator can steer away from faults; copy 1
    // follows the words the block actually accepts and yields the expected
    // results.
    t_code_addr ip_r   [2];
    t_code_addr plen_r [2];
    t_status    run_r  [2];
    int         dlvl   [2];
    int         rlvl   [2];
    t_word      dstk   [2][DSTK_DEPTH];
    t_code_addr rstk   [2][RSTK_DEPTH];
    t_word      regs   [2][REG_N];
    t_word      ram    [2][MEM_WORDS];
    t_word      vram   [2][MEM_WORDS];

    t_instr   instr_q[$];
    t_outcome outcome_q[$];
    int       mismatches = 0;
    int       n_results  = 0;
    int       idle_cycles = 0;

    // Executes one instruction on state copy s and returns the result word.
    function automatic t_outcome run_instr(input int s, input t_opcode c, input t_word o);
        t_outcome   r;
        t_word      a, b, ma, mb, q, v, res, bitv, addr;
        t_code_addr ipv, nxt, step1, step2, tgt;
        t_status    st;
        logic       take, ismem, isv, ispush;
        int         ri;
        r     = '0;
        st    = ST_RUN;
        ipv   = ip_r[s];
        nxt   = ipv;
        step1 = ipv + 16'd1;
        step2 = ipv + 16'd2;
        tgt   = o[15:0];
        if (run_r[s] == ST_RUN && ipv >= plen_r[s]) run_r[s] = ST_END;
        if (run_r[s] == ST_RUN) begin
            case (c)
                OP_PUSH: begin
                    if (dlvl[s] >= DSTK_DEPTH) begin
                        st = ST_OVER;
                    end else begin
                        dstk[s][dlvl[s]] = o;
                        dlvl[s]++;
                        nxt = step2;
                    end
                end
                OP_OUT: begin
                    if (dlvl[s] < 1) begin
                        st = ST_UNDER;
                    end else begin
                        dlvl[s]--;
                        r.pvalue = dstk[s][dlvl[s]];
                        r.pvalid = 1'b1;
                        nxt = step1;
                    end
                end
                OP_HLT: st = ST_HALT;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (dlvl[s] < 2) begin
                        st = ST_UNDER;
                    end else begin
                        b = dstk[s][dlvl[s]-1];
                        a = dstk[s][dlvl[s]-2];
                        if (c == OP_DIV && b == '0) begin
                            st = ST_DIVZ;
                        end else begin
                            case (c)
                                OP_ADD: a = a + b;
                                OP_SUB: a = a - b;
                                OP_MUL: a = a * b;
                                default: begin
                                    // Signed division on magnitudes, truncating
                                    // toward zero; min / -1 wraps to min.
                                    ma = a[63] ? -a : a;
                                    mb = b[63] ? -b : b;
                                    q  = ma / mb;
                                    a  = (a[63] != b[63]) ? -q : q;
                                end
                            endcase
                            dlvl[s]--;
                            dstk[s][dlvl[s]-1] = a;
                            nxt = step1;
                        end
                    end
                end
                OP_SQRT: begin
                    if (dlvl[s] < 1) begin
                        st = ST_UNDER;
                    end else if (dstk[s][dlvl[s]-1][63]) begin
                        st = ST_SQRTNEG;
                    end else begin
                        // Digit-by-digit floor square root.
                        v    = dstk[s][dlvl[s]-1];
                        res  = '0;
                        bitv = 64'd1 << 62;
                        while (bitv > v) bitv = bitv >> 2;
                        while (bitv != '0) begin
                            if (v >= res + bitv) begin
                                v   = v - (res + bitv);
                                res = (res >> 1) + bitv;
                            end else begin
                                res = res >> 1;
                            end
                            bitv = bitv >> 2;
                        end
                        dstk[s][dlvl[s]-1] = res;
                        nxt = step1;
                    end
                end
                OP_PUSHR, OP_POPR, OP_PUSHM, OP_POPM, OP_PUSHV, OP_POPV: begin
                    ismem  = (c != OP_PUSHR && c != OP_POPR);
                    isv    = (c == OP_PUSHV || c == OP_POPV);
                    ispush = (c == OP_PUSHR || c == OP_PUSHM || c == OP_PUSHV);
                    if (o >= REG_N) begin
                        st = ST_BADREG;
                    end else begin
                        ri   = int'(o[3:0]);
                        addr = regs[s][ri];
                        if (ismem && addr >= MEM_WORDS) begin
                            st = isv ? ST_VRAM : ST_RAM;
                        end else if (ispush) begin
                            if (dlvl[s] >= DSTK_DEPTH) begin
                                st = ST_OVER;
                            end else begin
                                dstk[s][dlvl[s]] = !ismem ? regs[s][ri] :
                                                   isv ? vram[s][addr[9:0]] : ram[s][addr[9:0]];
                                dlvl[s]++;
                                nxt = step2;
                            end
                        end else begin
                            if (dlvl[s] < 1) begin
                                st = ST_UNDER;
                            end else begin
                                dlvl[s]--;
                                a = dstk[s][dlvl[s]];
                                if (!ismem) regs[s][ri] = a;
                                else if (isv) vram[s][addr[9:0]] = a;
                                else ram[s][addr[9:0]] = a;
                                nxt = step2;
                            end
                        end
                    end
                end
                OP_JMP: nxt = tgt;
                OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
                    if (dlvl[s] < 2) begin
                        st = ST_UNDER;
                    end else begin
                        b = dstk[s][dlvl[s]-1];
                        a = dstk[s][dlvl[s]-2];
                        dlvl[s] -= 2;
                        case (c)
                            OP_JB:   take = $signed(a) <  $signed(b);
                            OP_JBE:  take = $signed(a) <= $signed(b);
                            OP_JA:   take = $signed(a) >  $signed(b);
                            OP_JAE:  take = $signed(a) >= $signed(b);
                            OP_JE:   take = (a == b);
                            default: take = (a != b);
                        endcase
                        nxt = take ? tgt : step2;
                    end
                end
                OP_CALL: begin
                    if (rlvl[s] >= RSTK_DEPTH) begin
                        st = ST_RETF;
                    end else begin
                        rstk[s][rlvl[s]] = step2;
                        rlvl[s]++;
                        nxt = tgt;
                    end
                end
                OP_RET: begin
                    if (rlvl[s] < 1) begin
                        st = ST_RETF;
                    end else begin
                        rlvl[s]--;
                        nxt = rstk[s][rlvl[s]];
                    end
                end
                OP_DRW: begin
                    r.drw = 1'b1;
                    nxt = step1;
                end
                OP_PAUSE: begin
                    r.pause = 1'b1;
                    nxt = step1;
                end
                default: st = ST_BADOP;
            endcase
            if (st == ST_RUN && nxt >= plen_r[s]) st = ST_END;
            if (st != ST_RUN && st != ST_END) nxt = ipv;
            ip_r[s]  = nxt;
            run_r[s] = st;
        end
        // A step that does nothing reports no print, draw or pause.
        if (run_r[s] != ST_RUN && r.st == ST_RUN && st == ST_RUN) begin
            r.pvalid = 1'b0;
            r.pvalue = '0;
            r.drw    = 1'b0;
            r.pause  = 1'b0;
        end
        r.addr = ip_r[s];
        r.st   = run_r[s];
        return r;
    endfunction

    // Queues one instruction for the driver and advances the generator's copy.
    task automatic emit(input t_opcode c, input t_word o);
        t_outcome dummy;
        instr_q.push_back('{cmd: c, opd: o});
        dummy = run_instr(0, c, o);
    endtask

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // A jump target below the safe top, with random upper bits that the
    // block must drop.
    function automatic t_word rand_target();
        t_word w;
        w = rand_word();
        w[15:0] = 16'($urandom_range(0, SAFE_TOP - 1));
        return w;
    endfunction

    function automatic t_word rand_value();
        case ($urandom_range(0, 9))
            0: return 64'h7FFF_FFFF_FFFF_FFFF;
            1: return 64'h8000_0000_0000_0000;
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            3, 4, 5: return 64'($urandom_range(0, MEM_WORDS - 1));
            default: return rand_word();
        endcase
    endfunction

    // Emits one random instruction that does not fault in the current state of the generator's
    // copy; a faulting pick is replaced by a push or a pop, and at the safe top a jump back is emitted.
    task automatic emit_random();
        t_opcode c;
        t_word   o;
        int      ri;
        logic    ok;
        o  = rand_word();
        ri = $urandom_range(0, REG_N - 1);
        if (ip_r[0] >= SAFE_TOP) begin
            emit(OP_JMP, rand_target());
            return;
        end
        c = t_opcode'($urandom_range(0, 24));
        case (c)
            OP_PUSH: ok = dlvl[0] < DSTK_DEPTH;
            OP_OUT: ok = dlvl[0] >= 1;
            OP_ADD, OP_SUB, OP_MUL: ok = dlvl[0] >= 2;
            OP_DIV: ok = dlvl[0] >= 2 && dstk[0][dlvl[0]-1] != '0;
            OP_SQRT: ok = dlvl[0] >= 1 && !dstk[0][dlvl[0]-1][63];
            OP_PUSHR: ok = dlvl[0] < DSTK_DEPTH;
            OP_POPR: ok = dlvl[0] >= 1;
            OP_PUSHM, OP_PUSHV: ok = dlvl[0] < DSTK_DEPTH && regs[0][ri] < MEM_WORDS;
            OP_POPM, OP_POPV: ok = dlvl[0] >= 1 && regs[0][ri] < MEM_WORDS;
            OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: ok = dlvl[0] >= 2;
            OP_CALL: ok = rlvl[0] < RSTK_DEPTH;
            OP_RET: ok = rlvl[0] >= 1;
            OP_JMP, OP_DRW, OP_PAUSE: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        if (!ok) begin
            // Keep the stack within bounds: push while it is low, else pop.
            if (dlvl[0] < DSTK_DEPTH - 8) emit(OP_PUSH, rand_value());
            else emit(OP_OUT, o);
            return;
        end
        case (c)
            OP_PUSH: o = rand_value();
            OP_PUSHR, OP_POPR, OP_PUSHM, OP_POPM, OP_PUSHV, OP_POPV: o = 64'(ri);
            OP_JMP, OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE, OP_CALL: o = rand_target();
            default: ;
        endcase
        emit(c, o);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] a, input logic [APB_DW-1:0] d);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // Read the register back to see that the write landed.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[15:0] !== d[15:0]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("program_length read back %0d, wrote %0d", prdata[15:0], d[15:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        plen_r[0] = d[15:0];
        plen_r[1] = d[15:0];
    endtask

    // Waits until every queued word has been taken and answered, then lets
    // the block settle before a register write.
    task automatic wait_drained();
        while (instr_q.size() != 0 || cmd_bus.valid || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Driver: sends words in bursts of random length with random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else if (!cmd_bus.valid || cmd_bus.ready) begin
            if (gap_left > 0) begin
                gap_left      <= gap_left - 1;
                cmd_bus.valid <= 1'b0;
            end else if (instr_q.size() != 0) begin
                t_instr it;
                it = instr_q.pop_front();
                cmd_bus.command <= it.cmd;
                cmd_bus.operand <= it.opd;
                cmd_bus.valid   <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls in modes of random length, and once holds off for a
    // long stretch so that the block backs up and stalls its input.
    int   mode       = 0;
    int   mode_left  = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            res_bus.ready <= 1'b0;
        end else if (!hold_done && n_results >= 200) begin
            hold_done     <= 1'b1;
            hold_left     <= 400;
            res_bus.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode      <= $urandom_range(0, 2);
                mode_left <= $urandom_range(10, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (mode)
                0: res_bus.ready <= 1'b1;
                1: res_bus.ready <= $urandom_range(0, 1);
                default: res_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: predicts on every accepted command word and checks every
    // accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_bus.valid && cmd_bus.ready)
                outcome_q.push_back(run_instr(1, cmd_bus.command, cmd_bus.operand));
            if (res_bus.valid && res_bus.ready) begin
                t_outcome want, got;
                got = '{addr: res_bus.next_address, pvalid: res_bus.print_valid,
                        pvalue: res_bus.print_value, drw: res_bus.draw_request,
                        pause: res_bus.pause_request, st: res_bus.status};
                n_results <= n_results + 1;
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result word with none expected");
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected addr=%0d pv=%0b val=%h drw=%0b ",
                                      "pause=%0b st=%0d, got addr=%0d pv=%0b val=%h drw=%0b ",
                                      "pause=%0b st=%0d"}, n_results,
                                     want.addr, want.pvalid, want.pvalue, want.drw,
                                     want.pause, want.st, got.addr, got.pvalid,
                                     got.pvalue, got.drw, got.pause, got.st);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int   ph, k;
        t_word o;
        cmd_bus.valid   = 1'b0;
        cmd_bus.command = '0;
        cmd_bus.operand = '0;
        res_bus.ready   = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_rst_n = 1'b0;
        for (int s = 0; s < 2; s++) begin
            ip_r[s] = '0; plen_r[s] = '0; run_r[s] = ST_RUN; dlvl[s] = 0; rlvl[s] = 0;
            foreach (dstk[s][j]) dstk[s][j] = '0;
            foreach (rstk[s][j]) rstk[s][j] = '0;
            foreach (regs[s][j]) regs[s][j] = '0;
            foreach (ram[s][j]) ram[s][j] = '0;
            foreach (vram[s][j]) vram[s][j] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_write(REG_PROGRAM_LENGTH, 32'd65535);

        // Directed: arithmetic wrap cases, floor root of the largest value,
        // register and memory moves at both ends of memory, every compare.
        emit(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        emit(OP_PUSH, 64'd1);
        emit(OP_ADD, rand_word());
        emit(OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
        emit(OP_MUL, rand_word());
        emit(OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
        emit(OP_DIV, rand_word());
        emit(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        emit(OP_SQRT, rand_word());
        emit(OP_SUB, rand_word());
        emit(OP_OUT, rand_word());
        emit(OP_PUSH, 64'd1023);
        emit(OP_POPR, 64'd2);
        emit(OP_PUSHR, 64'd3);
        emit(OP_POPM, 64'd3);
        emit(OP_PUSHM, 64'd3);
        emit(OP_POPV, 64'd2);
        emit(OP_PUSHV, 64'd2);
        emit(OP_OUT, rand_word());
        emit(OP_DRW, rand_word());
        emit(OP_PAUSE, rand_word());
        emit(OP_CALL, rand_target());
        emit(OP_RET, rand_word());
        for (int j = 0; j < 6; j++) begin
            o = 64'($urandom_range(0, 2)) - 64'd1;
            emit(OP_PUSH, o);
            emit(OP_PUSH, 64'h8000_0000_0000_0000 ^ o);
            emit(t_opcode'(OP_JB + j), rand_target());
        end
        emit(OP_JMP, rand_target());

        // Random phases, each with its own program length.
        for (ph = 0; ph < 4; ph++) begin
            for (k = 0; k < 370; k++) emit_random();
            wait_drained();
            case (ph)
                0: apb_write(REG_PROGRAM_LENGTH, 32'($urandom_range(1000, 65535)));
                1: apb_write(REG_PROGRAM_LENGTH, 32'd1000);
                default: apb_write(REG_PROGRAM_LENGTH, 32'd65535);
            endcase
        end

        // The run ends on one terminal event, chosen at random, since halt,
        // end and every fault are sticky until reset.
        case ($urandom_range(0, 12))
            0: emit(OP_HLT, rand_word());
            1: begin
                emit(OP_PUSH, rand_word());
                emit(OP_PUSH, 64'd0);
                emit(OP_DIV, rand_word());
            end
            2: begin
                emit(OP_PUSH, 64'h8000_0000_0000_0000 | rand_word());
                emit(OP_SQRT, rand_word());
            end
            3: emit(OP_PUSHR, $urandom_range(0, 1) ? (64'h8000_0000_0000_0000 | rand_word())
                                                   : 64'($urandom_range(REG_N, 4096)));
            4: begin
                emit(OP_PUSH, 64'($urandom_range(MEM_WORDS, 100000)));
                emit(OP_POPR, 64'd0);
                emit(OP_PUSHM, 64'd0);
            end
            5: begin
                emit(OP_PUSH, rand_word());
                emit(OP_PUSH, 64'h8000_0000_0000_0000 | rand_word());
                emit(OP_POPR, 64'd1);
                emit(OP_POPV, 64'd1);
            end
            6: begin
                while (dlvl[0] > 0) emit(OP_OUT, rand_word());
                emit(OP_ADD, rand_word());
            end
            7: begin
                while (dlvl[0] < DSTK_DEPTH) emit(OP_PUSH, rand_word());
                emit(OP_PUSH, rand_word());
            end
            8: begin
                while (rlvl[0] > 0) emit(OP_RET, rand_word());
                emit(OP_RET, rand_word());
            end
            9: begin
                while (rlvl[0] < RSTK_DEPTH) emit(OP_CALL, rand_target());
                emit(OP_CALL, rand_target());
            end
            10: emit(t_opcode'($urandom_range(25, 31)), rand_word());
            11: emit(OP_JMP, 64'hFFFF);
            default: begin
                wait_drained();
                apb_write(REG_PROGRAM_LENGTH, 32'd0);
                emit(OP_PUSH, rand_word());
            end
        endcase
        // Anything at all afterwards must leave the latched state alone.
        for (k = 0; k < 6; k++) emit(t_opcode'($urandom_range(0, 31)), rand_word());

        while (instr_q.size() != 0 || cmd_bus.valid || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
